// ----- design/fmm_pkg.sv -----
package fmm_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE_A  = 2'd0,
        FUNC_WRITE_B  = 2'd1,
        FUNC_MULTIPLY = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_ADD_WAIT,
        ST_OUT
    } state_t;

    localparam logic [1:0] CFG_ROWS_OF_A  = 2'd0;
    localparam logic [1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [1:0] CFG_COLS_OF_B  = 2'd2;

    localparam logic [3:0] DIM_RESET = 4'd8;

    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

    typedef logic signed [9:0] exp_t;

    // m: [25] hidden one, [24:2] fraction, [1] guard, [0] sticky; value 1.f * 2^(e-127)
    function automatic logic [31:0] round_pack(input logic sign, input exp_t e,
                                               input logic [25:0] m);
        logic [9:0]  sh;
        logic [25:0] mask;
        logic [25:0] ms;
        logic        sticky;
        logic [7:0]  eb;
        logic        up;
        logic [30:0] mag;
        begin
            sh     = '0;
            mask   = '0;
            ms     = m;
            sticky = 1'b0;
            eb     = '0;
            if (e > 10'sd254) begin
                round_pack = {sign, 8'hFF, 23'd0};
            end else begin
                if (e < 10'sd1) begin
                    // subnormal: denormalize with sticky jam
                    sh = unsigned'(10'sd1 - e);
                    if (sh > 10'd25) begin
                        ms     = '0;
                        sticky = |m;
                    end else begin
                        mask   = (26'd1 << sh[4:0]) - 26'd1;
                        ms     = m >> sh[4:0];
                        sticky = |(m & mask);
                    end
                    eb = 8'd0;
                end else begin
                    eb = e[7:0];
                end
                up  = ms[1] & (ms[0] | sticky | ms[2]);
                mag = {eb, ms[24:2]} + {30'd0, up};
                round_pack = {sign, mag};
            end
        end
    endfunction

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        begin
            n = '0;
            for (int i = 0; i < 48; i++) begin
                if (v[i]) n = 6'(47 - i);
            end
            lzc48 = n;
        end
    endfunction

    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] n;
        begin
            n = '0;
            for (int i = 0; i < 28; i++) begin
                if (v[i]) n = 5'(27 - i);
            end
            lzc28 = n;
        end
    endfunction

endpackage

// ----- design/float_matrix_multiply_core.sv -----
// Single-precision matrix multiply C = A x B. Load transfers (tuser 0 for A, 1 for B) write one
// element each. A multiply transfer (tuser 2) walks C in row-major order; every product term
// goes through one shared 4-stage multiplier and then one shared 6-stage adder, after a
// registered operand read from the element memories, and each C element leaves as one output transfer.
// s_tready stays low from the multiply transfer until the element flagged with m_tlast has been
// taken. Sums follow IEEE-754 round-to-nearest-even with a separate rounding per multiply and
// per add, starting from +0. Entries must be written before a multiply reads them.
module float_matrix_multiply_core #(
    parameter int MAX_DIM = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // row[2:0], col[5:3], value[37:6], zero fill
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_row[2:0], out_col[5:3], out_value[37:6], zero fill
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [3:0]  cfg_wdata
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [3:0] DIM_MAX = 4'(MAX_DIM);

    fmm_pkg::state_t state_reg, state_next;

    logic [3:0]  rows_reg, inner_reg, cols_reg;
    logic [2:0]  r_reg, r_next, c_reg, c_next, k_reg, k_next;
    logic [31:0] acc_reg, acc_next;

    logic [31:0] a_mem [DEPTH];
    logic [31:0] b_mem [DEPTH];
    logic [31:0] a_q, b_q;

    logic [3:0]  nr, nk, nc;
    logic [2:0]  in_row, in_col;
    logic [31:0] in_value;
    logic        s_xfer, in_range, we_a, we_b;
    logic [AW-1:0] waddr, a_raddr, b_raddr;

    logic        mul_start, mul_done, add_start, add_done;
    logic [31:0] mul_result, add_result;
    logic        last_k, last_elem;

    function automatic logic [3:0] eff_dim(input logic [3:0] v);
        if (v == 4'd0)         eff_dim = 4'd1;
        else if (v > DIM_MAX)  eff_dim = DIM_MAX;
        else                   eff_dim = v;
    endfunction

    assign nr = eff_dim(rows_reg);
    assign nk = eff_dim(inner_reg);
    assign nc = eff_dim(cols_reg);

    assign in_row   = s_tdata[2:0];
    assign in_col   = s_tdata[5:3];
    assign in_value = s_tdata[37:6];
    assign s_xfer   = s_tvalid && s_tready;
    assign in_range = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
    assign we_a = s_xfer && in_range && (fmm_pkg::func_t'(s_tuser) == fmm_pkg::FUNC_WRITE_A);
    assign we_b = s_xfer && in_range && (fmm_pkg::func_t'(s_tuser) == fmm_pkg::FUNC_WRITE_B);
    assign waddr   = AW'(int'(in_row) * MAX_DIM + int'(in_col));
    assign a_raddr = AW'(int'(r_reg) * MAX_DIM + int'(k_reg));
    assign b_raddr = AW'(int'(k_reg) * MAX_DIM + int'(c_reg));

    assign last_k    = (k_reg == 3'(nk - 4'd1));
    assign last_elem = (r_reg == 3'(nr - 4'd1)) && (c_reg == 3'(nc - 4'd1));

    always_ff @(posedge aclk) begin
        if (we_a) a_mem[waddr] <= in_value;
        if (we_b) b_mem[waddr] <= in_value;
        a_q <= a_mem[a_raddr];
        b_q <= b_mem[b_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= fmm_pkg::DIM_RESET;
            inner_reg <= fmm_pkg::DIM_RESET;
            cols_reg  <= fmm_pkg::DIM_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                fmm_pkg::CFG_ROWS_OF_A:  rows_reg  <= cfg_wdata;
                fmm_pkg::CFG_INNER_SIZE: inner_reg <= cfg_wdata;
                fmm_pkg::CFG_COLS_OF_B:  cols_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fmm_pkg::ST_IDLE;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    always_comb begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        mul_start  = 1'b0;
        add_start  = 1'b0;
        case (state_reg)
            fmm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && (fmm_pkg::func_t'(s_tuser) == fmm_pkg::FUNC_MULTIPLY)) begin
                    r_next     = '0;
                    c_next     = '0;
                    k_next     = '0;
                    acc_next   = '0;
                    state_next = fmm_pkg::ST_READ;
                end
            end
            fmm_pkg::ST_READ: begin
                state_next = fmm_pkg::ST_MUL_GO;
            end
            fmm_pkg::ST_MUL_GO: begin
                mul_start  = 1'b1;
                state_next = fmm_pkg::ST_MUL_WAIT;
            end
            fmm_pkg::ST_MUL_WAIT: begin
                if (mul_done) begin
                    add_start  = 1'b1;
                    state_next = fmm_pkg::ST_ADD_WAIT;
                end
            end
            fmm_pkg::ST_ADD_WAIT: begin
                if (add_done) begin
                    acc_next = add_result;
                    if (last_k) begin
                        state_next = fmm_pkg::ST_OUT;
                    end else begin
                        k_next     = k_reg + 3'd1;
                        state_next = fmm_pkg::ST_READ;
                    end
                end
            end
            fmm_pkg::ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (last_elem) begin
                        state_next = fmm_pkg::ST_IDLE;
                    end else begin
                        if (c_reg == 3'(nc - 4'd1)) begin
                            c_next = '0;
                            r_next = r_reg + 3'd1;
                        end else begin
                            c_next = c_reg + 3'd1;
                        end
                        k_next     = '0;
                        acc_next   = '0;
                        state_next = fmm_pkg::ST_READ;
                    end
                end
            end
            default: begin
                state_next = fmm_pkg::ST_IDLE;
            end
        endcase
    end

    fmm_fmul u_fmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (a_q),
        .op_b    (b_q),
        .done    (mul_done),
        .result  (mul_result)
    );

    fmm_fadd u_fadd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (add_start),
        .op_x    (acc_reg),
        .op_y    (mul_result),
        .done    (add_done),
        .result  (add_result)
    );

    assign m_tdata = {2'b00, acc_reg, c_reg, r_reg};
    assign m_tlast = last_elem;

endmodule

// ----- design/fmm_fmul.sv -----
module fmm_fmul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic        done,
    output logic [31:0] result
);

    logic [3:0]  vld_reg;

    logic        sign1_reg, sign2_reg, sign3_reg;
    logic        spec1_reg, spec2_reg, spec3_reg;
    logic [31:0] sval1_reg, sval2_reg, sval3_reg;
    logic [47:0] prod1_reg, prod2_reg;
    fmm_pkg::exp_t exp1_reg, exp2_reg, exp3_reg;
    logic [5:0]  lz2_reg;
    logic        zero2_reg, zero3_reg;
    logic [25:0] mant3_reg;
    logic [31:0] result_reg;

    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb;
    logic [7:0]  ea, eb;
    logic        spec_d;
    logic [31:0] sval_d;
    logic [47:0] pn;

    always_comb begin
        a_nan  = (op_a[30:23] == 8'hFF) && (op_a[22:0] != '0);
        b_nan  = (op_b[30:23] == 8'hFF) && (op_b[22:0] != '0);
        a_inf  = (op_a[30:23] == 8'hFF) && (op_a[22:0] == '0);
        b_inf  = (op_b[30:23] == 8'hFF) && (op_b[22:0] == '0);
        a_zero = (op_a[30:0] == '0);
        b_zero = (op_b[30:0] == '0);
        ma = {op_a[30:23] != '0, op_a[22:0]};
        mb = {op_b[30:23] != '0, op_b[22:0]};
        ea = (op_a[30:23] == '0) ? 8'd1 : op_a[30:23];
        eb = (op_b[30:23] == '0) ? 8'd1 : op_b[30:23];
        spec_d = 1'b1;
        if (a_nan)                                  sval_d = op_a | fmm_pkg::QUIET_BIT;
        else if (b_nan)                             sval_d = op_b | fmm_pkg::QUIET_BIT;
        else if ((a_inf && b_zero) || (b_inf && a_zero)) sval_d = fmm_pkg::QNAN_DEFAULT;
        else if (a_inf || b_inf)                    sval_d = {op_a[31] ^ op_b[31], 8'hFF, 23'd0};
        else begin
            sval_d = '0;
            spec_d = 1'b0;
        end
        pn = prod2_reg << lz2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[2:0], start};
        end
    end

    always_ff @(posedge aclk) begin
        sign1_reg <= op_a[31] ^ op_b[31];
        spec1_reg <= spec_d;
        sval1_reg <= sval_d;
        prod1_reg <= ma * mb;
        exp1_reg  <= fmm_pkg::exp_t'({2'b00, ea}) + fmm_pkg::exp_t'({2'b00, eb}) - 10'sd127;

        sign2_reg <= sign1_reg;
        spec2_reg <= spec1_reg;
        sval2_reg <= sval1_reg;
        prod2_reg <= prod1_reg;
        exp2_reg  <= exp1_reg;
        lz2_reg   <= fmm_pkg::lzc48(prod1_reg);
        zero2_reg <= (prod1_reg == '0);

        sign3_reg <= sign2_reg;
        spec3_reg <= spec2_reg;
        sval3_reg <= sval2_reg;
        zero3_reg <= zero2_reg;
        exp3_reg  <= exp2_reg + 10'sd1 - fmm_pkg::exp_t'({4'b0000, lz2_reg});
        mant3_reg <= {pn[47:23], |pn[22:0]};

        if (spec3_reg)      result_reg <= sval3_reg;
        else if (zero3_reg) result_reg <= {sign3_reg, 31'd0};
        else                result_reg <= fmm_pkg::round_pack(sign3_reg, exp3_reg, mant3_reg);
    end

    assign done   = vld_reg[3];
    assign result = result_reg;

endmodule

// ----- design/fmm_fadd.sv -----
module fmm_fadd (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] op_x,
    input  logic [31:0] op_y,
    output logic        done,
    output logic [31:0] result
);

    logic [5:0]  vld_reg;

    // stage payloads
    logic [23:0] bm1_reg, sm1_reg;
    logic [7:0]  d1_reg, e1_reg, e2_reg, e3_reg, e4_reg;
    logic        sub1_reg, sub2_reg;
    logic        sgn1_reg, sgn2_reg, sgn3_reg, sgn4_reg, sgn5_reg;
    logic        zs1_reg, zs2_reg, zs3_reg, zs4_reg, zs5_reg;
    logic        spec1_reg, spec2_reg, spec3_reg, spec4_reg, spec5_reg;
    logic [31:0] sval1_reg, sval2_reg, sval3_reg, sval4_reg, sval5_reg;
    logic [26:0] bm2_reg, sm2_reg;
    logic [27:0] sum3_reg, sum4_reg;
    logic [4:0]  lz4_reg;
    logic        zero4_reg, zero5_reg;
    fmm_pkg::exp_t exp5_reg;
    logic [25:0] mant5_reg;
    logic [31:0] result_reg;

    logic        x_nan, y_nan, x_inf, y_inf, x_big;
    logic [31:0] big, sml;
    logic [7:0]  be, se;
    logic        spec_d;
    logic [31:0] sval_d;
    logic [26:0] small27, shifted, mask;
    logic        st;
    logic [27:0] sn;

    always_comb begin
        x_nan = (op_x[30:23] == 8'hFF) && (op_x[22:0] != '0);
        y_nan = (op_y[30:23] == 8'hFF) && (op_y[22:0] != '0);
        x_inf = (op_x[30:23] == 8'hFF) && (op_x[22:0] == '0);
        y_inf = (op_y[30:23] == 8'hFF) && (op_y[22:0] == '0);
        spec_d = 1'b1;
        if (x_nan)                                sval_d = op_x | fmm_pkg::QUIET_BIT;
        else if (y_nan)                           sval_d = op_y | fmm_pkg::QUIET_BIT;
        else if (x_inf && y_inf && (op_x[31] != op_y[31])) sval_d = fmm_pkg::QNAN_DEFAULT;
        else if (x_inf)                           sval_d = op_x;
        else if (y_inf)                           sval_d = op_y;
        else begin
            sval_d = '0;
            spec_d = 1'b0;
        end
        x_big = (op_x[30:0] >= op_y[30:0]);
        big   = x_big ? op_x : op_y;
        sml   = x_big ? op_y : op_x;
        be    = (big[30:23] == '0) ? 8'd1 : big[30:23];
        se    = (sml[30:23] == '0) ? 8'd1 : sml[30:23];

        // align the smaller operand, jamming lost bits into the sticky position
        small27 = {sm1_reg, 3'b000};
        shifted = '0;
        mask    = '0;
        st      = 1'b0;
        if (d1_reg > 8'd26) begin
            st = |sm1_reg;
        end else begin
            mask    = (27'd1 << d1_reg[4:0]) - 27'd1;
            shifted = small27 >> d1_reg[4:0];
            st      = |(small27 & mask);
        end

        sn = sum4_reg << lz4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[4:0], start};
        end
    end

    always_ff @(posedge aclk) begin
        bm1_reg   <= {big[30:23] != '0, big[22:0]};
        sm1_reg   <= {sml[30:23] != '0, sml[22:0]};
        d1_reg    <= be - se;
        e1_reg    <= be;
        sub1_reg  <= op_x[31] ^ op_y[31];
        sgn1_reg  <= big[31];
        zs1_reg   <= op_x[31] & op_y[31];
        spec1_reg <= spec_d;
        sval1_reg <= sval_d;

        bm2_reg   <= {bm1_reg, 3'b000};
        sm2_reg   <= {shifted[26:1], shifted[0] | st};
        e2_reg    <= e1_reg;
        sub2_reg  <= sub1_reg;
        sgn2_reg  <= sgn1_reg;
        zs2_reg   <= zs1_reg;
        spec2_reg <= spec1_reg;
        sval2_reg <= sval1_reg;

        sum3_reg  <= sub2_reg ? ({1'b0, bm2_reg} - {1'b0, sm2_reg})
                              : ({1'b0, bm2_reg} + {1'b0, sm2_reg});
        e3_reg    <= e2_reg;
        sgn3_reg  <= sgn2_reg;
        zs3_reg   <= zs2_reg;
        spec3_reg <= spec2_reg;
        sval3_reg <= sval2_reg;

        sum4_reg  <= sum3_reg;
        lz4_reg   <= fmm_pkg::lzc28(sum3_reg);
        zero4_reg <= (sum3_reg == '0);
        e4_reg    <= e3_reg;
        sgn4_reg  <= sgn3_reg;
        zs4_reg   <= zs3_reg;
        spec4_reg <= spec3_reg;
        sval4_reg <= sval3_reg;

        exp5_reg  <= fmm_pkg::exp_t'({2'b00, e4_reg}) + 10'sd1
                     - fmm_pkg::exp_t'({5'b00000, lz4_reg});
        mant5_reg <= {sn[27:3], |sn[2:0]};
        zero5_reg <= zero4_reg;
        sgn5_reg  <= sgn4_reg;
        zs5_reg   <= zs4_reg;
        spec5_reg <= spec4_reg;
        sval5_reg <= sval4_reg;

        // exact cancellation gives +0 unless both operands were -0
        if (spec5_reg)      result_reg <= sval5_reg;
        else if (zero5_reg) result_reg <= {zs5_reg, 31'd0};
        else                result_reg <= fmm_pkg::round_pack(sgn5_reg, exp5_reg, mant5_reg);
    end

    assign done   = vld_reg[5];
    assign result = result_reg;

endmodule

// ----- design/fmm_checker.sv -----
module fmm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // input and output sides are never open together
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("ready while a result is pending");

    a_busy_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (fmm_pkg::func_t'(s_tuser) == fmm_pkg::FUNC_MULTIPLY)
        |=> !s_tready)
        else $error("ready right after a multiply transfer");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("not idle after the final result");

endmodule

bind float_matrix_multiply_core fmm_checker u_fmm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
